### rtl/core/pcv_pkg.sv
// package for the plate colour vote block
// holds class codes, register indexes, reset values and field widths
// no dependencies
package pcv_pkg;

	// widths of the pixel, position and register index fields
	localparam int PIXEL_BITS = 8;
	localparam int POS_BITS = 12;
	localparam int INDEX_BITS = 3;

	// default width of each class counter
	localparam int COUNT_BITS_DEFAULT = 20;

	// colour class code
	typedef logic [2:0] color_t;

	localparam color_t CLASS_BLUE = 3'd0;
	localparam color_t CLASS_YELLOW = 3'd1;
	localparam color_t CLASS_WHITE = 3'd2;
	localparam color_t CLASS_BLACK = 3'd3;
	localparam color_t CLASS_OTHER = 3'd4;

	localparam int NUM_CLASSES = 5;

	// configuration register indexes
	localparam logic [INDEX_BITS-1:0] REG_FRAME_WIDTH = 3'd0;
	localparam logic [INDEX_BITS-1:0] REG_CROP_LEFT = 3'd1;
	localparam logic [INDEX_BITS-1:0] REG_CROP_RIGHT_LAST = 3'd2;
	localparam logic [INDEX_BITS-1:0] REG_CROP_TOP = 3'd3;
	localparam logic [INDEX_BITS-1:0] REG_CROP_BOTTOM_LAST = 3'd4;

	// reset values of the configuration registers and the row limit
	localparam logic [POS_BITS-1:0] FRAME_WIDTH_RESET = 12'd1;
	localparam logic [POS_BITS-1:0] POS_MAX = 12'd4095;

endpackage

### rtl/core/plate_color_vote.sv
// plate colour vote: pixel classifier, per-class counters and frame vote
// depends on pcv_pkg
//
// Takes one RGB pixel per cycle in raster order. Pixels that fall inside the
// crop window are sorted into blue, yellow, white, black or other by exact
// integer HSV rules and counted in saturating per-class counters of
// COUNT_BITS bits. The pixel flagged end_of_frame closes the frame: its
// colour vote appears on the result port after it has passed through the
// input register, count snapshot, merged sums and result register, and the
// counters and position counters start from zero for the next frame.
// Pixels that do not end a frame give no result. Input is stalled only when
// an end-of-frame pixel cannot move into the snapshot stage, which happens
// only while several frame results are backed up at the result port; in
// steady state one pixel is taken every cycle. Configuration must be written
// while no frame is in progress.
module plate_color_vote
	import pcv_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  write_enable,
	input  logic [INDEX_BITS-1:0] write_index,
	input  logic [POS_BITS-1:0]   write_data,
	// pixel input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIXEL_BITS-1:0] red,
	input  logic [PIXEL_BITS-1:0] green,
	input  logic [PIXEL_BITS-1:0] blue,
	input  logic                  end_of_frame,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output color_t                plate_color,
	output logic                  invert_binary
);

	localparam int SUM_BITS = COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// configuration registers
	logic [POS_BITS-1:0] frame_width_q;
	logic [POS_BITS-1:0] crop_left_q;
	logic [POS_BITS-1:0] crop_right_last_q;
	logic [POS_BITS-1:0] crop_top_q;
	logic [POS_BITS-1:0] crop_bottom_last_q;

	// position counters
	logic [POS_BITS-1:0] column_q;
	logic [POS_BITS-1:0] row_q;

	// stage 1: registered pixel
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] red_s1;
	logic [PIXEL_BITS-1:0] green_s1;
	logic [PIXEL_BITS-1:0] blue_s1;
	logic                  eof_s1;
	logic                  in_window_s1;

	// class counters
	logic [COUNT_BITS-1:0] class_count_q [NUM_CLASSES];
	logic [COUNT_BITS-1:0] class_count_next [NUM_CLASSES];

	// stage 2: snapshot of the closing frame
	logic                  valid_s2;
	logic [COUNT_BITS-1:0] count_s2 [NUM_CLASSES];

	// stage 3: merged counts
	logic                valid_s3;
	logic [SUM_BITS-1:0] merged_s3 [NUM_CLASSES];
	logic                white_ge_black_s3;

	// result register
	logic   out_valid_q;
	color_t plate_color_q;
	logic   invert_binary_q;

	// handshake and stage movement
	logic accept;
	logic out_ready;
	logic ready_s3;
	logic ready_s2;
	logic retire_s1;
	logic to_s2;

	assign out_ready = !out_valid_q || !out_stall;
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign retire_s1 = valid_s1 && (!eof_s1 || ready_s2);
	assign to_s2 = retire_s1 && eof_s1;
	assign in_stall = valid_s1 && eof_s1 && !ready_s2;
	assign accept = in_valid && !in_stall;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RESET;
			crop_left_q <= '0;
			crop_right_last_q <= POS_MAX;
			crop_top_q <= '0;
			crop_bottom_last_q <= POS_MAX;
		end else if (write_enable) begin
			unique case (write_index)
				REG_FRAME_WIDTH: frame_width_q <= write_data;
				REG_CROP_LEFT: crop_left_q <= write_data;
				REG_CROP_RIGHT_LAST: crop_right_last_q <= write_data;
				REG_CROP_TOP: crop_top_q <= write_data;
				REG_CROP_BOTTOM_LAST: crop_bottom_last_q <= write_data;
				default: ;
			endcase
		end
	end

	// crop window test on the position of the incoming pixel
	logic in_window;
	assign in_window = (column_q >= crop_left_q) && (column_q <= crop_right_last_q)
		&& (row_q >= crop_top_q) && (row_q <= crop_bottom_last_q);

	// raster position, width zero behaves as width one
	logic [POS_BITS:0] column_inc;
	assign column_inc = {1'b0, column_q} + {{POS_BITS{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				column_q <= '0;
				row_q <= '0;
			end else if (column_inc >= {1'b0, frame_width_q}) begin
				column_q <= '0;
				if (row_q != POS_MAX) begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				column_q <= column_inc[POS_BITS-1:0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1 <= red;
			green_s1 <= green;
			blue_s1 <= blue;
			eof_s1 <= end_of_frame;
			in_window_s1 <= in_window;
		end
	end

	// max, min and spread of the registered pixel
	logic [PIXEL_BITS-1:0] max_c;
	logic [PIXEL_BITS-1:0] min_c;
	logic [PIXEL_BITS-1:0] spread;

	always_comb begin
		max_c = red_s1;
		if (green_s1 > max_c) max_c = green_s1;
		if (blue_s1 > max_c) max_c = blue_s1;
		min_c = red_s1;
		if (green_s1 < min_c) min_c = green_s1;
		if (blue_s1 < min_c) min_c = blue_s1;
		spread = max_c - min_c;
	end

	// value and saturation thresholds by cross-multiplication
	logic [11:0] max_x5;
	logic [11:0] max_x7;
	logic [11:0] min_x10;
	logic        is_black;
	logic        is_white;

	assign max_x5 = {4'b0, max_c} * 12'd5;
	assign max_x7 = {4'b0, max_c} * 12'd7;
	assign min_x10 = {4'b0, min_c} * 12'd10;
	assign is_black = max_x5 < 12'd255;
	assign is_white = (min_x10 > max_x7) && (min_c >= 8'd100);

	// hue tests in signed arithmetic, spread scaled by one and by two
	logic signed [11:0] red_x;
	logic signed [11:0] green_x;
	logic signed [11:0] blue_x;
	logic signed [11:0] spread_x;
	logic signed [11:0] spread_x2;
	logic signed [11:0] hue_gb;
	logic signed [11:0] hue_rb;
	logic signed [11:0] hue_rg;

	assign red_x = $signed({4'b0, red_s1});
	assign green_x = $signed({4'b0, green_s1});
	assign blue_x = $signed({4'b0, blue_s1});
	assign spread_x = $signed({4'b0, spread});
	assign spread_x2 = spread_x + spread_x;
	assign hue_gb = (green_x - blue_x) * 12'sd3;
	assign hue_rb = (red_x - blue_x) * 12'sd3;
	assign hue_rg = (red_x - green_x) * 12'sd3;

	// class decision
	color_t pixel_class;

	always_comb begin
		pixel_class = CLASS_OTHER;
		if (is_black) begin
			pixel_class = CLASS_BLACK;
		end else if (is_white) begin
			pixel_class = CLASS_WHITE;
		end else if (spread == '0) begin
			pixel_class = CLASS_OTHER;
		end else if (max_c == red_s1) begin
			// red maximum, magenta side of red is other
			if (green_s1 >= blue_s1 && hue_gb >= spread_x) begin
				pixel_class = CLASS_YELLOW;
			end
		end else if (max_c == green_s1) begin
			if (hue_rb >= spread_x) begin
				pixel_class = CLASS_YELLOW;
			end
		end else begin
			if (hue_rg >= -spread_x2 && hue_rg <= spread_x2) begin
				pixel_class = CLASS_BLUE;
			end
		end
	end

	// saturating counter update for the pixel leaving stage 1
	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			class_count_next[i] = class_count_q[i];
			if (in_window_s1 && pixel_class == color_t'(i)
				&& class_count_q[i] != COUNT_MAX) begin
				class_count_next[i] = class_count_q[i] + 1'b1;
			end
		end
	end

	// counters clear once the closing frame moves to the snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) class_count_q[i] <= '0;
		end else if (retire_s1) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				class_count_q[i] <= eof_s1 ? '0 : class_count_next[i];
			end
		end
	end

	// stage 2: final counts of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= to_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (to_s2) begin
			for (int i = 0; i < NUM_CLASSES; i++) count_s2[i] <= class_count_next[i];
		end
	end

	// stage 3: merged counts at full width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			merged_s3[0] <= {1'b0, count_s2[0]} + {1'b0, count_s2[2]};
			merged_s3[1] <= {1'b0, count_s2[1]} + {1'b0, count_s2[3]};
			merged_s3[2] <= {1'b0, count_s2[2]} + {1'b0, count_s2[3]};
			merged_s3[3] <= {1'b0, count_s2[2]} + {1'b0, count_s2[3]};
			merged_s3[4] <= {1'b0, count_s2[4]};
			white_ge_black_s3 <= count_s2[2] >= count_s2[3];
		end
	end

	// vote: first strict maximum, white against black settles the shared pair
	color_t        vote_win;
	color_t        vote_color;
	logic [SUM_BITS-1:0] vote_best;

	always_comb begin
		vote_best = '0;
		vote_win = CLASS_BLUE;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (vote_best < merged_s3[i]) begin
				vote_best = merged_s3[i];
				vote_win = color_t'(i);
			end
		end
		vote_color = vote_win;
		if (vote_win == CLASS_WHITE || vote_win == CLASS_BLACK) begin
			vote_color = white_ge_black_s3 ? CLASS_WHITE : CLASS_BLACK;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s3) begin
			plate_color_q <= vote_color;
			invert_binary_q <= (vote_color == CLASS_YELLOW) || (vote_color == CLASS_WHITE);
		end
	end

	assign out_valid = out_valid_q;
	assign plate_color = plate_color_q;
	assign invert_binary = invert_binary_q;

	// input holds off only behind a blocked end-of-frame pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && eof_s1 && valid_s2))
		else $error("input stalled without a blocked end-of-frame pixel");

	// counters start from zero after a frame closes
	assert property (@(posedge clk) disable iff (!arst_n)
		to_s2 |=> (class_count_q[0] == '0 && class_count_q[1] == '0
			&& class_count_q[2] == '0 && class_count_q[3] == '0
			&& class_count_q[4] == '0))
		else $error("class counters not cleared after end of frame");

	// a blocked snapshot is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> (valid_s2 && $stable(count_s2[0])
			&& $stable(count_s2[2]) && $stable(count_s2[3])))
		else $error("frame snapshot changed while blocked");

endmodule
